[src/vcrb_pkg.sv]
package vcrb_pkg;

	typedef struct packed {
		logic [2:0]         action;
		logic [23:0]        offset;
		logic [7:0]         write_data;
		logic [31:0]        tick_cycles;
		logic signed [15:0] pointer_x_in;
		logic signed [15:0] pointer_y_in;
	} vcrb_req_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        rom_hit;
		logic [11:0] rom_index;
		logic        irq;
		logic [1:0]  power_request;
	} vcrb_rsp_t;

	localparam int unsigned VRAM_BYTES_DEF = 1048576;

	localparam logic [2:0] ACT_READ  = 3'd0;
	localparam logic [2:0] ACT_WRITE = 3'd1;
	localparam logic [2:0] ACT_TICK  = 3'd2;
	localparam logic [2:0] ACT_PTR   = 3'd3;
	localparam logic [2:0] ACT_TAKE  = 3'd4;

	localparam logic [1:0] CFG_MAX_DEPTH = 2'd0;
	localparam logic [1:0] CFG_ABS_PTR   = 2'd1;
	localparam logic [1:0] CFG_SCR_W     = 2'd2;
	localparam logic [1:0] CFG_SCR_H     = 2'd3;

	localparam logic [23:0] ROM_WINDOW    = 24'hF00000;
	localparam logic [23:0] REG_DEPTH     = 24'h080000;
	localparam logic [23:0] REG_IRQ_EN    = 24'h080001;
	localparam logic [23:0] REG_PAL_IDX   = 24'h080002;
	localparam logic [23:0] REG_PAL_R     = 24'h080003;
	localparam logic [23:0] REG_PAL_G     = 24'h080004;
	localparam logic [23:0] REG_PAL_B     = 24'h080005;
	localparam logic [23:0] SERVICES_BASE = 24'd524304;
	localparam logic [23:0] COMMAND_ADDR  = 24'd524310;
	localparam logic [23:0] POINTER_BASE  = 24'd524320;

	localparam logic [7:0] SVC_VERSION = 8'd2;
	localparam logic [7:0] CMD_POWEROFF = 8'd1;
	localparam logic [7:0] CMD_RESTART  = 8'd2;
	localparam logic [1:0] PREQ_NONE     = 2'd0;
	localparam logic [1:0] PREQ_POWEROFF = 2'd1;
	localparam logic [1:0] PREQ_RESTART  = 2'd2;
	localparam logic [7:0] DEPTH_CODES  = 8'd6;

	// vbl period is 509 << 9, so the wrap needs only a mod 509 on the upper bits
	localparam logic [17:0] VBL_PERIOD = 18'd260608;
	localparam int          VBL_SHIFT  = 9;
	localparam logic [8:0]  VBL_ODD    = 9'd509;
	localparam logic [23:0] VBL_RECIP  = 24'((64'd1 << 32) / 64'd509);
	localparam logic [24:0] GRACE_CYCLES = 25'd23454720;

	localparam logic [12:0] SCR_W_MIN = 13'd320;
	localparam logic [12:0] SCR_W_MAX = 13'd4096;
	localparam logic [11:0] SCR_H_MIN = 12'd200;
	localparam logic [11:0] SCR_H_MAX = 12'd2160;

	function automatic logic [7:0] svc_sig(input logic [1:0] idx);
		logic [7:0] c;
		unique case (idx)
			2'd0: c = 8'h43;
			2'd1: c = 8'h54;
			2'd2: c = 8'h4D;
			2'd3: c = 8'h43;
			default: c = 8'h43;
		endcase
		return c;
	endfunction

endpackage

[src/vcrb_vbl_mod.sv]
module vcrb_vbl_mod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [22:0] dividend,
	output logic        vld,
	output logic [8:0]  rem
);
	import vcrb_pkg::*;

	logic        vld_s1, vld_s2;
	logic [22:0] e_s1, e_s2;
	logic [46:0] prod_s1;
	logic [23:0] qp_s2;
	logic [22:0] r_raw;
	logic [9:0]  r_fix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= go;
			vld_s2 <= vld_s1;
		end
	end

	// quotient estimate is low by at most one
	always_ff @(posedge clk) begin
		e_s1    <= dividend;
		prod_s1 <= 47'(dividend) * 47'(VBL_RECIP);
		e_s2    <= e_s1;
		qp_s2   <= 24'(prod_s1[46:32]) * 24'(VBL_ODD);
	end

	assign r_raw = e_s2 - qp_s2[22:0];
	assign r_fix = (r_raw[9:0] >= 10'(VBL_ODD)) ? r_raw[9:0] - 10'(VBL_ODD) : r_raw[9:0];
	assign rem   = r_fix[8:0];
	assign vld   = vld_s2;

endmodule

[src/video_card_register_block.sv]
// register and video memory block of a slot video card
// request channel: drive req and raise start; it is taken on a clock edge where
// start is high and busy is low. busy stays high while a request is worked on.
// result channel: done pulses for one cycle with rsp; every request gives one
// result, and the receiver cannot stall it.
// execution: a request is taken, executed in the next cycle (video memory and
// palette reads land then), and its result shows in the cycle after that; busy
// drops together with done, so a new request can be taken once done shows.
// a tick that wraps the vertical-blank counter also waits for the pipelined
// mod-509 unit before its result shows.
// configuration: APB-style port, registers at byte addresses 0, 4, 8, 12,
// which the user writes only while the block is idle; the block itself does not enforce this.
// reset: the palette reads as a descending grey ramp through per-entry valid
// bits; video memory is zeroed by a clearing pass over all VRAM_BYTES addresses
// (1048576 by default) during which busy is high and no request is taken.
module video_card_register_block #(
	parameter int unsigned VRAM_BYTES = vcrb_pkg::VRAM_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                start,
	output logic                busy,
	input  vcrb_pkg::vcrb_req_t req,
	output logic                done,
	output vcrb_pkg::vcrb_rsp_t rsp
);
	import vcrb_pkg::*;

	localparam int VA = $clog2(VRAM_BYTES);
	localparam logic [23:0] VRAM_TOP = 24'(VRAM_BYTES);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_EXEC  = 4'b0100,
		ST_TWAIT = 4'b1000
	} state_t;

	state_t      state_q;
	logic [VA-1:0] clr_q;
	vcrb_req_t   req_q;
	vcrb_rsp_t   rsp_q;
	logic        done_q;

	logic [2:0]  max_depth_q;
	logic        abs_ptr_q;
	logic [12:0] scr_w_q;
	logic [11:0] scr_h_q;

	logic [7:0]  vram [VRAM_BYTES];
	logic [7:0]  vram_rd_q;
	logic [23:0] pal_mem [256];
	logic [23:0] pal_rd_q;
	logic        pal_vld_rd_q;
	logic [255:0] pal_vld_q;

	logic [7:0]  pidx_q;
	logic [7:0]  latch_r_q, latch_g_q, latch_b_q;
	logic [2:0]  depth_q;
	logic        vbl_en_q, irq_q;
	logic [17:0] vbl_cd_q;
	logic [1:0]  pend_q;
	logic        defer_q;
	logic [24:0] grace_q;
	logic [11:0] ptr_x_q, ptr_y_q;
	logic [7:0]  ptr_seq_q;
	logic        ptr_vld_q;
	logic [8:0]  low_q;

	logic        accept, cfg_we, exec;
	logic [23:0] off;
	logic [7:0]  wd;
	logic        act_rd, act_wr, act_tick, act_ptr, act_take;
	logic        wr_vram, pal_we, vram_we;
	logic [VA-1:0] vram_wa;
	logic [7:0]  vram_wd;
	logic [23:0] pal_word;
	logic [7:0]  rd_byte;
	logic        irq_nx;
	logic        tick_wrap;
	logic [31:0] tick_diff;
	logic [12:0] w_cl;
	logic [11:0] h_cl, lim_x, lim_y, nx, ny;
	logic        ptr_chg;
	logic        mod_vld;
	logic [8:0]  mod_rem;
	vcrb_rsp_t   rsp_nx;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign cfg_we = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign done   = done_q;
	assign rsp    = rsp_q;
	assign exec   = (state_q == ST_EXEC);

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_depth_q <= 3'd3;
			abs_ptr_q   <= 1'b0;
			scr_w_q     <= 13'd640;
			scr_h_q     <= 12'd480;
		end else if (cfg_we) begin
			unique case (paddr[3:2])
				CFG_MAX_DEPTH: max_depth_q <= pwdata[2:0];
				CFG_ABS_PTR:   abs_ptr_q   <= pwdata[0];
				CFG_SCR_W:     scr_w_q     <= pwdata[12:0];
				CFG_SCR_H:     scr_h_q     <= pwdata[11:0];
				default:       max_depth_q <= max_depth_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			CFG_MAX_DEPTH: prdata = {29'd0, max_depth_q};
			CFG_ABS_PTR:   prdata = {31'd0, abs_ptr_q};
			CFG_SCR_W:     prdata = {19'd0, scr_w_q};
			CFG_SCR_H:     prdata = {20'd0, scr_h_q};
			default:       prdata = 32'd0;
		endcase
	end

	assign off      = req_q.offset;
	assign wd       = req_q.write_data;
	assign act_rd   = (req_q.action == ACT_READ);
	assign act_wr   = (req_q.action == ACT_WRITE);
	assign act_tick = (req_q.action == ACT_TICK);
	assign act_ptr  = (req_q.action == ACT_PTR);
	assign act_take = (req_q.action == ACT_TAKE);

	// video memory, single write port shared with the clearing pass
	assign wr_vram = (off != REG_DEPTH) && (off != REG_IRQ_EN) && (off != REG_PAL_IDX)
		&& (off != REG_PAL_R) && (off != REG_PAL_G) && (off != REG_PAL_B)
		&& (off != COMMAND_ADDR) && (off < VRAM_TOP);
	assign vram_we = (state_q == ST_CLEAR) || (exec && act_wr && wr_vram);
	assign vram_wa = (state_q == ST_CLEAR) ? clr_q : off[VA-1:0];
	assign vram_wd = (state_q == ST_CLEAR) ? 8'd0 : wd;

	always_ff @(posedge clk) begin
		if (vram_we)
			vram[vram_wa] <= vram_wd;
		if (accept)
			vram_rd_q <= vram[req.offset[VA-1:0]];
	end

	// palette: entries never written read as the grey ramp
	assign pal_we = exec && act_wr && (off == REG_PAL_B) && (pidx_q != 8'd0)
		&& (pidx_q != 8'd255);

	always_ff @(posedge clk) begin
		if (pal_we)
			pal_mem[pidx_q] <= {latch_r_q, latch_g_q, wd};
		if (accept)
			pal_rd_q <= pal_mem[pidx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_vld_q    <= '0;
			pal_vld_rd_q <= 1'b0;
		end else begin
			if (pal_we)
				pal_vld_q[pidx_q] <= 1'b1;
			if (accept)
				pal_vld_rd_q <= pal_vld_q[pidx_q];
		end
	end

	assign pal_word = pal_vld_rd_q ? pal_rd_q : {~pidx_q, ~pidx_q, ~pidx_q};

	always_comb begin
		priority if (off == REG_DEPTH)                    rd_byte = {5'd0, depth_q};
		else if (off == REG_IRQ_EN)                       rd_byte = {7'd0, !vbl_en_q};
		else if (off == REG_PAL_IDX)                      rd_byte = pidx_q;
		else if (off == REG_PAL_R)                        rd_byte = pal_word[23:16];
		else if (off == REG_PAL_G)                        rd_byte = pal_word[15:8];
		else if (off == REG_PAL_B)                        rd_byte = pal_word[7:0];
		else if (off >= SERVICES_BASE && off < SERVICES_BASE + 24'd4)
			rd_byte = svc_sig(2'(off - SERVICES_BASE));
		else if (off == SERVICES_BASE + 24'd4)            rd_byte = SVC_VERSION;
		else if (off == SERVICES_BASE + 24'd5)            rd_byte = {6'd0, abs_ptr_q, 1'b1};
		else if (off == COMMAND_ADDR)                     rd_byte = 8'd0;
		else if (off == POINTER_BASE)                     rd_byte = {7'd0, ptr_vld_q};
		else if (off == POINTER_BASE + 24'd1)             rd_byte = ptr_seq_q;
		else if (off == POINTER_BASE + 24'd2)             rd_byte = {4'd0, ptr_x_q[11:8]};
		else if (off == POINTER_BASE + 24'd3)             rd_byte = ptr_x_q[7:0];
		else if (off == POINTER_BASE + 24'd4)             rd_byte = {4'd0, ptr_y_q[11:8]};
		else if (off == POINTER_BASE + 24'd5)             rd_byte = ptr_y_q[7:0];
		else if (off < VRAM_TOP)                          rd_byte = vram_rd_q;
		else                                              rd_byte = 8'hFF;
	end

	// pointer clamping to the screen
	always_comb begin
		priority if (scr_w_q < SCR_W_MIN)      w_cl = SCR_W_MIN;
		else if (scr_w_q > SCR_W_MAX)          w_cl = SCR_W_MAX;
		else                                   w_cl = scr_w_q;
		priority if (scr_h_q < SCR_H_MIN)      h_cl = SCR_H_MIN;
		else if (scr_h_q > SCR_H_MAX)          h_cl = SCR_H_MAX;
		else                                   h_cl = scr_h_q;
		lim_x = 12'(w_cl - 13'd1);
		lim_y = h_cl - 12'd1;
		priority if (req_q.pointer_x_in[15])                      nx = 12'd0;
		else if ({1'b0, req_q.pointer_x_in[14:0]} > {4'd0, lim_x}) nx = lim_x;
		else                                                       nx = req_q.pointer_x_in[11:0];
		priority if (req_q.pointer_y_in[15])                      ny = 12'd0;
		else if ({1'b0, req_q.pointer_y_in[14:0]} > {4'd0, lim_y}) ny = lim_y;
		else                                                       ny = req_q.pointer_y_in[11:0];
	end

	assign ptr_chg   = !ptr_vld_q || (nx != ptr_x_q) || (ny != ptr_y_q);
	assign tick_wrap = (req_q.tick_cycles >= {14'd0, vbl_cd_q});
	assign tick_diff = req_q.tick_cycles - {14'd0, vbl_cd_q};

	assign irq_nx = (act_wr && off == REG_IRQ_EN && wd == 8'd0) ? 1'b0 : irq_q;

	always_comb begin
		rsp_nx.read_data     = (act_rd && off < ROM_WINDOW) ? rd_byte : 8'd0;
		rsp_nx.rom_hit       = act_rd && (off >= ROM_WINDOW);
		rsp_nx.rom_index     = (act_rd && off >= ROM_WINDOW) ? off[11:0] : 12'd0;
		rsp_nx.irq           = irq_nx;
		rsp_nx.power_request = act_take ? pend_q : PREQ_NONE;
	end

	vcrb_vbl_mod u_vbl_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (exec && act_tick && tick_wrap),
		.dividend (tick_diff[31:VBL_SHIFT]),
		.vld      (mod_vld),
		.rem      (mod_rem)
	);

	always_ff @(posedge clk) begin
		if (accept)
			req_q <= req;
		if (exec) begin
			rsp_q <= rsp_nx;
			low_q <= tick_diff[VBL_SHIFT-1:0];
		end else if (state_q == ST_TWAIT)
			rsp_q.irq <= vbl_en_q | irq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			done_q    <= 1'b0;
			pidx_q    <= 8'd0;
			latch_r_q <= 8'd0;
			latch_g_q <= 8'd0;
			latch_b_q <= 8'd0;
			depth_q   <= 3'd0;
			vbl_en_q  <= 1'b0;
			irq_q     <= 1'b0;
			vbl_cd_q  <= VBL_PERIOD;
			pend_q    <= PREQ_NONE;
			defer_q   <= 1'b0;
			grace_q   <= 25'd0;
			ptr_x_q   <= 12'd0;
			ptr_y_q   <= 12'd0;
			ptr_seq_q <= 8'd0;
			ptr_vld_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == VA'(VRAM_BYTES - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					irq_q   <= irq_nx;
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					if (act_wr) begin
						priority if (off == REG_DEPTH) begin
							if (wd < DEPTH_CODES && wd <= {5'd0, max_depth_q})
								depth_q <= wd[2:0];
						end else if (off == REG_IRQ_EN) begin
							vbl_en_q <= (wd == 8'd0);
						end else if (off == REG_PAL_IDX) begin
							pidx_q <= wd;
						end else if (off == REG_PAL_R) begin
							latch_r_q <= wd;
						end else if (off == REG_PAL_G) begin
							latch_g_q <= wd;
						end else if (off == REG_PAL_B) begin
							latch_b_q <= wd;
							pidx_q    <= pidx_q + 8'd1;
						end else if (off == COMMAND_ADDR) begin
							if (wd == CMD_POWEROFF) begin
								defer_q <= 1'b1;
								grace_q <= GRACE_CYCLES;
							end else if (wd == CMD_RESTART)
								pend_q <= PREQ_RESTART;
						end
					end
					if (act_tick) begin
						if (defer_q) begin
							if (req_q.tick_cycles >= {7'd0, grace_q}) begin
								pend_q  <= PREQ_POWEROFF;
								defer_q <= 1'b0;
								grace_q <= 25'd0;
							end else
								grace_q <= grace_q - req_q.tick_cycles[24:0];
						end
						if (tick_wrap) begin
							state_q <= ST_TWAIT;
							done_q  <= 1'b0;
						end else
							vbl_cd_q <= vbl_cd_q - req_q.tick_cycles[17:0];
					end
					if (act_ptr && abs_ptr_q && ptr_chg) begin
						ptr_x_q   <= nx;
						ptr_y_q   <= ny;
						ptr_seq_q <= ptr_seq_q + 8'd1;
						ptr_vld_q <= 1'b1;
					end
					if (act_take)
						pend_q <= PREQ_NONE;
				end
				ST_TWAIT: begin
					if (mod_vld) begin
						vbl_cd_q <= VBL_PERIOD - {mod_rem, low_q};
						if (vbl_en_q)
							irq_q <= 1'b1;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy) else $error("not busy after request");
	a_vbl_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vbl_cd_q != 18'd0) && (vbl_cd_q <= VBL_PERIOD)) else $error("vbl counter out of range");
	a_pend_code: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3) else $error("bad power request code");
`endif

endmodule
